/* src/slpc_pkg.sv */
// shared types, constants and lookup tables of the srgb pixel converter
package slpc_pkg;

    localparam int     LINEAR_BITS = 16;
    localparam longint LIN_MAX     = (longint'(1) << LINEAR_BITS) - 1;
    localparam int     CODE_BITS   = 8;
    localparam int     NUM_CH      = 4;
    localparam int     CH_ALPHA    = 3;
    localparam int     PIX_W       = NUM_CH * CODE_BITS;
    localparam int     TAB_DEPTH   = 1 << CODE_BITS;
    localparam longint CURVE_DEN   = 10761;
    localparam int     BIG_W       = 320;

    // table selectors for the elaboration-time builder
    localparam int TAB_DEC       = 0;
    localparam int TAB_DEC_ALPHA = 1;
    localparam int TAB_ENC       = 2;
    localparam int TAB_ENC_ALPHA = 3;

    typedef logic [LINEAR_BITS-1:0] lin_t;
    typedef logic [CODE_BITS-1:0]   code_t;
    typedef logic [BIG_W-1:0]       big_t;
    typedef lin_t                   lin_tab_t [TAB_DEPTH];

    // x^5 * y^12, exact
    function automatic big_t big_powprod(input longint x, input longint y);
        big_t r;
        big_t bx;
        big_t by;
        bx = big_t'(x);
        by = big_t'(y);
        r  = big_t'(1);
        for (int i = 0; i < 5; i++)
        begin
            r = r * bx;
        end
        for (int i = 0; i < 12; i++)
        begin
            r = r * by;
        end
        return r;
    endfunction

    // colour code to linear value, rounded half up
    function automatic lin_t dec_colour(input longint c);
        longint lo;
        longint hi;
        longint mid;
        big_t   lhs;
        big_t   rhs;
        if (c <= 10)
        begin
            return lin_t'((200 * LIN_MAX * c + 329460) / 658920);
        end
        rhs = big_powprod(2 * LIN_MAX, 40 * c + 561);
        lo  = 0;
        hi  = LIN_MAX;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = big_powprod(2 * mid - 1, CURVE_DEN);
            if (lhs <= rhs)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return lin_t'(lo);
    endfunction

    // smallest linear value that rounds up to code k
    function automatic lin_t enc_colour_thr(input longint k);
        longint lo;
        longint hi;
        longint mid;
        big_t   lhs;
        big_t   rhs;
        if (k == 0)
        begin
            return '0;
        end
        if (k <= 10)
        begin
            return lin_t'(((2 * k - 1) * 100 * LIN_MAX + 658919) / 658920);
        end
        rhs = big_powprod(LIN_MAX, 40 * k + 541);
        lo  = 0;
        hi  = LIN_MAX;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            lhs = big_powprod(mid, CURVE_DEN);
            if (lhs >= rhs)
            begin
                hi = mid;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        return lin_t'(lo);
    endfunction

    function automatic lin_t dec_alpha(input longint a);
        return lin_t'((2 * a * LIN_MAX + 255) / 510);
    endfunction

    function automatic lin_t enc_alpha_thr(input longint k);
        if (k == 0)
        begin
            return '0;
        end
        return lin_t'(((2 * k - 1) * LIN_MAX + 509) / 510);
    endfunction

    function automatic lin_tab_t build_tab(input int sel);
        lin_tab_t t;
        for (int i = 0; i < TAB_DEPTH; i++)
        begin
            case (sel)
                TAB_DEC:       t[i] = dec_colour(longint'(i));
                TAB_DEC_ALPHA: t[i] = dec_alpha(longint'(i));
                TAB_ENC:       t[i] = enc_colour_thr(longint'(i));
                TAB_ENC_ALPHA: t[i] = enc_alpha_thr(longint'(i));
                default:       t[i] = '0;
            endcase
        end
        return t;
    endfunction

    localparam lin_tab_t DEC_TAB       = build_tab(TAB_DEC);
    localparam lin_tab_t DEC_ALPHA_TAB = build_tab(TAB_DEC_ALPHA);
    localparam lin_tab_t ENC_TAB       = build_tab(TAB_ENC);
    localparam lin_tab_t ENC_ALPHA_TAB = build_tab(TAB_ENC_ALPHA);

endpackage

/* src/slpc_if.sv */
// request and response channel interfaces of the srgb pixel converter
interface slpc_in_if import slpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [PIX_W-1:0]  packed_srgb;
    lin_t              lin_red;
    lin_t              lin_green;
    lin_t              lin_blue;
    lin_t              lin_alpha;

    modport source (output valid, output kind, output packed_srgb, output lin_red,
                    output lin_green, output lin_blue, output lin_alpha, input ready);
    modport sink   (input valid, input kind, input packed_srgb, input lin_red,
                    input lin_green, input lin_blue, input lin_alpha, output ready);
endinterface

interface slpc_out_if import slpc_pkg::*; ();
    logic              valid;
    logic              ready;
    lin_t              out_red;
    lin_t              out_green;
    lin_t              out_blue;
    lin_t              out_alpha;
    logic [PIX_W-1:0]  out_packed;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output out_packed, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, input out_packed, output ready);
endinterface

/* src/slpc_dec_rom.sv */
// decode rom: srgb code to linear value, registered read
module slpc_dec_rom import slpc_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [PIX_W-1:0] pix,
    output lin_t             q [NUM_CH]
);

    localparam lin_tab_t COLOUR_ROM = DEC_TAB;
    localparam lin_tab_t ALPHA_ROM  = DEC_ALPHA_TAB;

    code_t addr [NUM_CH];

    // red in the top byte
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            addr[ch] = pix[(NUM_CH - 1 - ch) * CODE_BITS +: CODE_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                if (ch == CH_ALPHA)
                begin
                    q[ch] <= ALPHA_ROM[addr[ch]];
                end
                else
                begin
                    q[ch] <= COLOUR_ROM[addr[ch]];
                end
            end
        end
    end

endmodule

/* src/srgb_linear_pixel_convert.sv */
// top level of the srgb / linear pixel converter
//
//  channel | modport      | transaction
//  --------+--------------+------------------------------------------------
//  req     | slpc_in_if   | kind, packed rgba8 word, four linear channels
//  rsp     | slpc_out_if  | four linear channels, packed rgba8 word
//
// one pixel per clock sustained while the response side is ready
// the pipeline depth is set by the encode search: one code bit per stage over eight
// stages of threshold compares, with the decode rom read in the first stage
// reset clears the stage valid bits only; no table needs a clearing pass
// a stalled response holds the last stage; earlier stages keep moving and
// close up bubbles, so a request is taken while any stage is free
module srgb_linear_pixel_convert import slpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    slpc_in_if.sink     req,
    slpc_out_if.source  rsp
);

    // stage 0 holds the request, stages 1..LAST the search and the rom data
    localparam int LAST = CODE_BITS;

    logic [LAST:0]     v_reg;
    logic [LAST:0]     v_next;
    logic [LAST:0]     leave;
    logic [LAST:0]     free;
    logic              accept;

    logic [PIX_W-1:0]  pix_reg;
    lin_t              lin_reg  [0:LAST-1][NUM_CH];
    code_t             code_reg [0:LAST][NUM_CH];
    code_t             pick     [1:LAST][NUM_CH];
    lin_t              rom_q    [NUM_CH];
    lin_t              dec_reg  [2:LAST][NUM_CH];

    // stage handshake: a stage is free when empty or when its item moves on
    always_comb
    begin
        leave[LAST] = v_reg[LAST] && rsp.ready;
        free[LAST]  = !v_reg[LAST] || rsp.ready;
        for (int s = LAST - 1; s >= 0; s--)
        begin
            leave[s] = v_reg[s] && free[s + 1];
            free[s]  = !v_reg[s] || free[s + 1];
        end
    end

    assign req.ready = free[0];
    assign accept    = req.valid && free[0];

    always_comb
    begin
        v_next[0] = accept || (v_reg[0] && !leave[0]);
        for (int s = 1; s <= LAST; s++)
        begin
            v_next[s] = leave[s - 1] || (v_reg[s] && !leave[s]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // request capture; the unused side is zeroed so that it yields zero
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= req.kind ? '0 : req.packed_srgb;
        end
    end

    // decode path: one registered rom read per channel
    slpc_dec_rom u_dec_rom
    (
        .clk (clk),
        .en  (leave[0]),
        .pix (pix_reg),
        .q   (rom_q)
    );

    // encode path: code = largest k whose rounding threshold is reached,
    // found msb first, one bit per stage
    always_comb
    begin
        code_t cand;
        lin_t  thr;
        for (int j = 1; j <= LAST; j++)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                cand = code_reg[j - 1][ch] | (code_t'(1) << (LAST - j));
                if (ch == CH_ALPHA)
                begin
                    thr = ENC_ALPHA_TAB[cand];
                end
                else
                begin
                    thr = ENC_TAB[cand];
                end
                pick[j][ch] = (lin_reg[j - 1][ch] >= thr) ? cand : code_reg[j - 1][ch];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // linear side of the request enters the search with an empty code
        if (accept)
        begin
            lin_reg[0][0] <= req.kind ? req.lin_red   : '0;
            lin_reg[0][1] <= req.kind ? req.lin_green : '0;
            lin_reg[0][2] <= req.kind ? req.lin_blue  : '0;
            lin_reg[0][3] <= req.kind ? req.lin_alpha : '0;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                code_reg[0][ch] <= '0;
            end
        end
        for (int j = 1; j <= LAST; j++)
        begin
            if (leave[j - 1])
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    code_reg[j][ch] <= pick[j][ch];
                end
            end
        end
        for (int j = 1; j < LAST; j++)
        begin
            if (leave[j - 1])
            begin
                lin_reg[j] <= lin_reg[j - 1];
            end
        end
        // decoded values ride along behind the rom
        if (leave[1])
        begin
            dec_reg[2] <= rom_q;
        end
        for (int j = 3; j <= LAST; j++)
        begin
            if (leave[j - 1])
            begin
                dec_reg[j] <= dec_reg[j - 1];
            end
        end
    end

    assign rsp.valid      = v_reg[LAST];
    assign rsp.out_red    = dec_reg[LAST][0];
    assign rsp.out_green  = dec_reg[LAST][1];
    assign rsp.out_blue   = dec_reg[LAST][2];
    assign rsp.out_alpha  = dec_reg[LAST][3];
    assign rsp.out_packed = {code_reg[LAST][0], code_reg[LAST][1],
                             code_reg[LAST][2], code_reg[LAST][CH_ALPHA]};

`ifndef ASSERT_OFF
    // a refused request means every stage is occupied
    a_full_when_refused: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (&v_reg))
        else $error("request refused with a free stage");

    // an item leaving the capture stage lands in the rom stage
    a_rom_stage_filled: assert property (@(posedge clk) disable iff (!rst_n)
        leave[0] |=> v_reg[1])
        else $error("item lost between capture and rom stage");

    // a response carries either a decoded pixel or an encoded word, never both
    a_one_side_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.out_packed == '0) ||
                      (rsp.out_red == '0 && rsp.out_green == '0 &&
                       rsp.out_blue == '0 && rsp.out_alpha == '0))
        else $error("response mixes decode and encode results");
`endif

endmodule

/* tb/srgb_linear_pixel_convert_test.sv */
// self-checking testbench of the srgb / linear pixel converter, with its own exact predictor
`timescale 1ns / 100ps

module srgb_linear_pixel_convert_test;
    import slpc_pkg::*;

    // wide enough for a 5th power of a 17 bit value times a 12th power of a 14 bit value
    typedef logic [319:0] wide_t;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] rgba;
        lin_t             red;
        lin_t             green;
        lin_t             blue;
        lin_t             alpha;
    } pixel_req_t;

    typedef struct packed {
        lin_t             red;
        lin_t             green;
        lin_t             blue;
        lin_t             alpha;
        logic [PIX_W-1:0] rgba;
    } pixel_rsp_t;

    typedef struct packed {
        pixel_req_t px;
        logic       typed;
        pixel_rsp_t want;
    } stim_row_t;

    // transaction kinds
    localparam logic KIND_DECODE = 1'b0;
    localparam logic KIND_ENCODE = 1'b1;

    // where a directed row takes its expected response from
    localparam logic CHECK_PREDICTED = 1'b0;
    localparam logic CHECK_TYPED     = 1'b1;

    localparam int RANDOM_PER_PHASE = 475;
    localparam int NUM_PHASES       = 4;

    // idle and stall rates per phase: none, sender only, receiver only, both
    localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 49, 0, 37};
    localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 49, 37};

    logic clk;
    logic rst_n;

    slpc_in_if  req_if ();
    slpc_out_if rsp_if ();

    srgb_linear_pixel_convert u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // decoded value of every colour code, and the exact rounding bound of every
    // code on the power part of the encoding curve
    lin_t  lin_of_code [TAB_DEPTH];
    wide_t code_bound  [TAB_DEPTH];
    wide_t den_pow12;

    pixel_rsp_t awaited_pixels [$];
    stim_row_t  directed_rows  [$];

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_request   = 0;
    int mismatch_count = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // generous cap on the whole run
    initial
    begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic wide_t ipow(input longint base, input int n);
        wide_t acc;
        acc = wide_t'(1);
        for (int i = 0; i < n; i++)
        begin
            acc = acc * wide_t'(base);
        end
        return acc;
    endfunction

    // linear value to colour code: binary search over the codes, testing whether
    // the value reaches the half-code bound below each candidate
    function automatic code_t gamma_encode(input lin_t l);
        wide_t lhs;
        int    lo;
        int    hi;
        int    mid;
        logic  hit;
        lhs = ipow(longint'(l), 5) * den_pow12;
        lo  = 0;
        hi  = 255;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid <= 10)
            begin
                // straight segment of the curve
                hit = longint'(l) * 658920 >= longint'(2 * mid - 1) * 100 * LIN_MAX;
            end
            else
            begin
                hit = lhs >= code_bound[mid];
            end
            if (hit)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return code_t'(lo);
    endfunction

    // expected response of one request; fields that a kind does not produce stay zero
    function automatic pixel_rsp_t convert_pixel(input pixel_req_t px);
        pixel_rsp_t r;
        longint     a;
        r = '0;
        if (px.kind == KIND_DECODE)
        begin
            r.red   = lin_of_code[px.rgba[31:24]];
            r.green = lin_of_code[px.rgba[23:16]];
            r.blue  = lin_of_code[px.rgba[15:8]];
            r.alpha = lin_t'((2 * longint'(px.rgba[7:0]) * LIN_MAX + 255) / 510);
        end
        else
        begin
            a = (longint'(px.alpha) * 510 + LIN_MAX) / (2 * LIN_MAX);
            if (a > 255)
            begin
                a = 255;
            end
            r.rgba = {gamma_encode(px.red), gamma_encode(px.green), gamma_encode(px.blue),
                      code_t'(a)};
        end
        return r;
    endfunction

    // linear values lean towards the straight segment, the knee and the extremes
    function automatic lin_t pick_linear();
        case ($urandom_range(0, 3))
            0: return lin_t'($urandom_range(0, 400));
            1: return ($urandom_range(0, 1) == 1) ? lin_t'(LIN_MAX) : lin_t'($urandom_range(0, 2));
            default: return lin_t'($urandom);
        endcase
    endfunction

    // colour codes lean towards the straight segment and the start of the power part
    function automatic code_t pick_code();
        if ($urandom_range(0, 3) == 0)
        begin
            return code_t'($urandom_range(0, 12));
        end
        return code_t'($urandom);
    endfunction

    // fields unused by the chosen kind are left random on purpose
    function automatic pixel_req_t random_pixel();
        pixel_req_t px;
        px.kind  = logic'($urandom_range(0, 1));
        px.rgba  = {pick_code(), pick_code(), pick_code(), code_t'($urandom)};
        px.red   = pick_linear();
        px.green = pick_linear();
        px.blue  = pick_linear();
        px.alpha = lin_t'($urandom);
        return px;
    endfunction

    task automatic add_row(input logic kind, input logic [PIX_W-1:0] rgba,
                           input lin_t red, input lin_t green, input lin_t blue,
                           input lin_t alpha, input logic typed, input pixel_rsp_t want);
        stim_row_t row;
        row.px    = {kind, rgba, red, green, blue, alpha};
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // offer one request, with random idle cycles ahead of it, and log its expected
    // response once the transaction is taken
    task automatic send_pixel(input pixel_req_t px, input logic typed, input pixel_rsp_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= px.kind;
        req_if.packed_srgb <= px.rgba;
        req_if.lin_red     <= px.red;
        req_if.lin_green   <= px.green;
        req_if.lin_blue    <= px.blue;
        req_if.lin_alpha   <= px.alpha;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        awaited_pixels.push_back(typed ? want : convert_pixel(px));
    endtask

    // sender goes quiet until every expected response has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (awaited_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // response side: check every accepted transaction against the oldest
    // expectation, then choose ready for the next cycle
    initial
    begin : response_side
        pixel_rsp_t got;
        pixel_rsp_t want;
        int         hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            begin
                got = {rsp_if.out_red, rsp_if.out_green, rsp_if.out_blue, rsp_if.out_alpha,
                       rsp_if.out_packed};
                if (awaited_pixels.size() == 0)
                begin
                    $error("response with nothing awaited: out_packed 0x%0h", got.rgba);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_pixels.pop_front();
                    check_field("out_red", want.red, got.red);
                    check_field("out_green", want.green, got.green);
                    check_field("out_blue", want.blue, got.blue);
                    check_field("out_alpha", want.alpha, got.alpha);
                    check_field("out_packed", want.rgba, got.rgba);
                end
            end
            // a long hold-off is counted here, independent of the sender
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial
    begin : stimulus
        wide_t rhs;
        wide_t s_pow5;
        int    lo;
        int    hi;
        int    mid;

        // every input known from the start, reset held low
        rst_n                <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.kind          <= KIND_DECODE;
        req_if.packed_srgb   <= '0;
        req_if.lin_red       <= '0;
        req_if.lin_green     <= '0;
        req_if.lin_blue      <= '0;
        req_if.lin_alpha     <= '0;
        rsp_if.ready         <= 1'b0;

        // predictor tables; the power part is settled by comparing exact 5th powers of
        // linear fractions with 12th powers of rationals with denominator CURVE_DEN
        den_pow12 = ipow(CURVE_DEN, 12);
        s_pow5    = ipow(LIN_MAX, 5);
        for (int c = 0; c < TAB_DEPTH; c++)
        begin
            if (c <= 10)
            begin
                // straight segment, c / 12.92 rounded half up
                lin_of_code[c] = lin_t'((200 * LIN_MAX * c + 329460) / 658920);
                code_bound[c]  = '0;
            end
            else
            begin
                // largest value v with (2v - 1) / 2S not above the curve at c
                rhs = ipow(2 * LIN_MAX, 5) * ipow(40 * c + 561, 12);
                lo  = 0;
                hi  = int'(LIN_MAX);
                while (lo < hi)
                begin
                    mid = lo + (hi - lo + 1) / 2;
                    if (ipow(2 * mid - 1, 5) * den_pow12 <= rhs)
                    begin
                        lo = mid;
                    end
                    else
                    begin
                        hi = mid - 1;
                    end
                end
                lin_of_code[c] = lin_t'(lo);
                code_bound[c]  = s_pow5 * ipow(40 * c + 541, 12);
            end
        end

        // black and white both ways, alpha alone, junk in the unused fields
        add_row(KIND_DECODE, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                CHECK_TYPED, {16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0});
        add_row(KIND_DECODE, 32'hFFFF_FFFF, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                CHECK_TYPED, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0});
        add_row(KIND_DECODE, 32'h0000_00FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                CHECK_TYPED, {16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 32'h0});
        add_row(KIND_DECODE, 32'h0000_0080, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                CHECK_TYPED, {16'h0000, 16'h0000, 16'h0000, 16'h8080, 32'h0});
        add_row(KIND_ENCODE, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                CHECK_TYPED, {16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0});
        add_row(KIND_ENCODE, 32'h1234_5678, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                CHECK_TYPED, {16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF});
        add_row(KIND_ENCODE, 32'hA5A5_A5A5, 16'h0000, 16'h0000, 16'h0000, 16'h5A5A,
                CHECK_TYPED, {16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_005A});
        // decode: straight segment, its last code and the start of the power part
        add_row(KIND_DECODE, 32'h0A0B_0C01, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                CHECK_PREDICTED, '0);
        add_row(KIND_DECODE, 32'h0102_0304, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                CHECK_PREDICTED, '0);
        add_row(KIND_DECODE, 32'h0809_0D7F, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                CHECK_PREDICTED, '0);
        add_row(KIND_DECODE, 32'h8040_2010, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                CHECK_PREDICTED, '0);
        add_row(KIND_DECODE, 32'hA5A5_5A5A, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0,
                CHECK_PREDICTED, '0);
        add_row(KIND_DECODE, 32'h5A5A_A5A5, 16'hF0F0, 16'h0F0F, 16'hF0F0, 16'h0F0F,
                CHECK_PREDICTED, '0);
        add_row(KIND_DECODE, 32'hFE01_FE01, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                CHECK_PREDICTED, '0);
        // encode: straight segment, either side of the knee, alpha either side of a half
        add_row(KIND_ENCODE, 32'h0000_0000, 16'd1, 16'd2, 16'd100, 16'd128,
                CHECK_PREDICTED, '0);
        add_row(KIND_ENCODE, 32'hFFFF_FFFF, 16'd204, 16'd205, 16'd206, 16'd129,
                CHECK_PREDICTED, '0);
        add_row(KIND_ENCODE, 32'h0000_0000, 16'd207, 16'd3, 16'd10, 16'd385,
                CHECK_PREDICTED, '0);
        add_row(KIND_ENCODE, 32'h0000_0000, 16'h8000, 16'h4000, 16'h2000, 16'h8080,
                CHECK_PREDICTED, '0);
        add_row(KIND_ENCODE, 32'hFFFF_FFFF, 16'hFFFE, 16'hFFFD, 16'h7FFF, 16'hFFFE,
                CHECK_PREDICTED, '0);
        add_row(KIND_ENCODE, 32'h0000_0000, 16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F,
                CHECK_PREDICTED, '0);
        add_row(KIND_ENCODE, 32'hFFFF_FFFF, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0,
                CHECK_PREDICTED, '0);
        add_row(KIND_ENCODE, 32'h0000_0000, 16'h00FF, 16'hFF00, 16'h1234, 16'hFEDC,
                CHECK_PREDICTED, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at full rate
        foreach (directed_rows[i])
        begin
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
        end
        wait_drained();

        // random phases, each ending with the sender paused until all responses are in
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct = SEND_IDLE_PCT[phase];
            stall_pct     = RECV_STALL_PCT[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // long receiver hold-off while requests keep coming: the
                // pipeline fills and must push back on the request side
                if (phase == 0 && n == 100)
                begin
                    hold_request = 60;
                end
                send_pixel(random_pixel(), CHECK_PREDICTED, '0);
            end
            wait_drained();
        end

        // room for any stray response beyond the pipeline latency
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
src/slpc_pkg.sv
src/slpc_if.sv
src/slpc_dec_rom.sv
src/srgb_linear_pixel_convert.sv
tb/srgb_linear_pixel_convert_test.sv
